FILE: src/bpc_pkg.sv
// Shared types, constants and helpers for the barometric compensation pipeline.
// No dependencies; compile first.
`timescale 1ns / 1ps
`default_nettype none

package bpc_pkg;

    // Pipelined divider: one quotient bit per register stage
    localparam int DIV_LAT = 32;
    // Total register stages from the input register to the output register
    localparam int PIPE_DEPTH = 2 * DIV_LAT + 17;

    typedef enum logic [2:0] {
        CFG_CAL_A = 3'd0,
        CFG_CAL_B = 3'd1,
        CFG_CAL_C = 3'd2,
        CFG_OSS   = 3'd3,
        CFG_MG    = 3'd4,
        CFG_MH    = 3'd5,
        CFG_MI    = 3'd6
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ERR_OK   = 2'd0,
        ERR_TEMP = 2'd1,
        ERR_PRES = 2'd2
    } err_t;

    // sign-extend a 16-bit word to 32 bits
    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    // arithmetic right shift of a 32-bit two's complement word
    function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] s);
        return $signed(v) >>> s;
    endfunction

endpackage

`default_nettype wire

FILE: src/bpc_if.sv
// Channel interfaces: sample input, result output and configuration write.
// Does not use bpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bpc_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] raw_temperature;
    logic [23:0] raw_pressure;
    modport source (output valid, output raw_temperature, output raw_pressure, input ready);
    modport sink   (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

interface bpc_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] temperature_tenths;
    logic [31:0] pressure_pa;
    logic [31:0] altitude_m;
    logic [1:0]  error_code;
    modport source (output valid, output temperature_tenths, output pressure_pa,
                    output altitude_m, output error_code, input ready);
    modport sink   (input valid, input temperature_tenths, input pressure_pa,
                    input altitude_m, input error_code, output ready);
endinterface

interface bpc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: src/barometric_pressure_compensation_unit.sv
// Top level of the barometric compensation pipeline.
// Depends on bpc_pkg, the channel interfaces in bpc_if.sv and bpc_udiv.
//
// Usage:
//   sample : raw temperature word and raw 24-bit pressure word in, one word
//            per valid/ready handshake.
//   result : temperature in 0.1 degC, pressure in Pa, altitude in m and an
//            error code (1: temperature divisor zero, 2: pressure divisor
//            zero; all values zero then).
//   cfg    : register writes by index (calibration groups, oversampling,
//            correction terms); always ready, write only while idle.
// Throughput: one sample per cycle while results are taken.
// Stages: 17 arithmetic stages plus two 32-stage dividers (temperature
//   and pressure), each resolving one quotient bit per stage.
// Reset clears all valid bits and loads the register reset values.
// Stall: when a result waits untaken the whole pipe holds, and sample.ready
//   drops; nothing is lost or repeated. Ready returns as soon as the
//   output word is taken.
`timescale 1ns / 1ps
`default_nettype none

module barometric_pressure_compensation_unit (
    input  wire logic clk,
    input  wire logic rst_n,
    bpc_in_if.sink    sample,
    bpc_out_if.source result,
    bpc_cfg_if.sink   cfg
);
    import bpc_pkg::*;

    typedef struct packed {
        logic [31:0] x1;
        logic        neg;
        err_t        err;
        logic [23:0] up;
    } side1_t;

    typedef struct packed {
        logic [15:0] t;
        err_t        err;
        logic        big;
    } side2_t;

    // ---------------- configuration registers ----------------
    logic [63:0] cal_a_reg;
    logic [63:0] cal_b_reg;
    logic [31:0] cal_c_reg;
    logic [1:0]  oss_reg;
    logic [15:0] mg_reg;
    logic [15:0] mh_reg;
    logic [15:0] mi_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_a_reg <= '0;
            cal_b_reg <= '0;
            cal_c_reg <= '0;
            oss_reg   <= 2'd3;
            mg_reg    <= 16'd3038;
            mh_reg    <= 16'hE343;
            mi_reg    <= 16'd3791;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_CAL_A: cal_a_reg <= cfg.data;
                CFG_CAL_B: cal_b_reg <= cfg.data;
                CFG_CAL_C: cal_c_reg <= cfg.data[31:0];
                CFG_OSS:   oss_reg   <= cfg.data[1:0];
                CFG_MG:    mg_reg    <= cfg.data[15:0];
                CFG_MH:    mh_reg    <= cfg.data[15:0];
                CFG_MI:    mi_reg    <= cfg.data[15:0];
                default: ;
            endcase
        end
    end

    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, mg, mh, mi;
    assign ac1 = sx16(cal_a_reg[63:48]);
    assign ac2 = sx16(cal_a_reg[47:32]);
    assign ac3 = sx16(cal_a_reg[31:16]);
    assign ac4 = {16'd0, cal_a_reg[15:0]};
    assign ac5 = {16'd0, cal_b_reg[63:48]};
    assign ac6 = {16'd0, cal_b_reg[47:32]};
    assign b1  = sx16(cal_b_reg[31:16]);
    assign b2  = sx16(cal_b_reg[15:0]);
    assign mc  = sx16(cal_c_reg[31:16]);
    assign md  = sx16(cal_c_reg[15:0]);
    assign mg  = sx16(mg_reg);
    assign mh  = sx16(mh_reg);
    assign mi  = sx16(mi_reg);

    // ---------------- flow control ----------------
    // One enable for every stage: advance whenever the output slot is free.
    logic adv;
    logic [PIPE_DEPTH-1:0] valid_reg;

    assign adv          = !valid_reg[PIPE_DEPTH-1] || result.ready;
    assign sample.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[PIPE_DEPTH-2:0], sample.valid};
    end

    // ---------------- P0: input register, oversampling shift ----------------
    logic [15:0] ut0_reg;
    logic [23:0] up0_reg;
    logic [3:0]  up_shamt;
    assign up_shamt = 4'd8 - {2'b00, oss_reg};

    // ---------------- P1: x1 product ----------------
    logic [31:0] mul1_reg;
    logic [23:0] up1_reg;

    // ---------------- P2: temperature divisor setup ----------------
    // The divider operands are registered once more here, before its first stage,
    // so the side data runs one stage longer than the divider itself.
    logic [31:0] x1_c, dv_c, num_c;
    logic [31:0] ma2_reg, mb2_reg;
    side1_t      s1_next;
    side1_t      s1_reg [DIV_LAT+1];

    assign x1_c  = asr32(mul1_reg, 5'd15);
    assign dv_c  = x1_c + md;
    assign num_c = mc << 11;

    always_comb
    begin
        s1_next.x1  = x1_c;
        s1_next.neg = num_c[31] ^ dv_c[31];
        s1_next.err = (dv_c == 32'd0) ? ERR_TEMP : ERR_OK;
        s1_next.up  = up1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ut0_reg  <= sample.raw_temperature;
            up0_reg  <= sample.raw_pressure >> up_shamt;
            mul1_reg <= ({16'd0, ut0_reg} - ac6) * ac5;
            up1_reg  <= up0_reg;
            ma2_reg  <= num_c[31] ? (32'd0 - num_c) : num_c;
            mb2_reg  <= dv_c[31] ? (32'd0 - dv_c) : dv_c;
            s1_reg[0] <= s1_next;
            for (int i = 1; i < DIV_LAT + 1; i++)
                s1_reg[i] <= s1_reg[i-1];
        end
    end

    logic [31:0] quo1;
    bpc_udiv u_div_temp (
        .clk      (clk),
        .en       (adv),
        .dividend (ma2_reg),
        .divisor  (mb2_reg),
        .quotient (quo1)
    );

    // ---------------- P3: B5, temperature, B6 ----------------
    side1_t      s1o;
    logic [31:0] q1_c, b5_c, t_c;
    assign s1o  = s1_reg[DIV_LAT];
    assign q1_c = s1o.neg ? (32'd0 - quo1) : quo1;
    assign b5_c = s1o.x1 + q1_c;
    assign t_c  = asr32(b5_c + 32'd8, 5'd4);

    logic [15:0] t3_reg, t4_reg, t5_reg, t6_reg, t7_reg;
    err_t        e3_reg, e4_reg, e5_reg, e6_reg, e7_reg;
    logic [23:0] up3_reg, up4_reg, up5_reg, up6_reg;
    logic [31:0] b6_3_reg;

    // ---------------- P4..P7: B3, B4, B7 ----------------
    logic [31:0] sq4_reg, m2_4_reg, m3_4_reg;
    logic [31:0] mb2_5_reg, mb1_5_reg, m2_5_reg, m3_5_reg;
    logic [31:0] b3_6_reg, x3b_6_reg;
    logic [31:0] b4_7_reg, b7_7_reg;

    logic [31:0] sqs_c, x3_c, u3_c, w3_c, b3_c, x3b_c, x3b_sum_c, b4p_c;
    assign sqs_c     = asr32(sq4_reg, 5'd12);
    assign x3_c      = asr32(mb2_5_reg, 5'd11) + asr32(m2_5_reg, 5'd11);
    assign u3_c      = (ac1 << 2) + x3_c;
    assign w3_c      = (u3_c << oss_reg) + 32'd2;
    assign b3_c      = asr32(w3_c, 5'd2);
    assign x3b_sum_c = asr32(m3_5_reg, 5'd13) + asr32(mb1_5_reg, 5'd16) + 32'd2;
    assign x3b_c     = asr32(x3b_sum_c, 5'd2);
    assign b4p_c     = ac4 * (x3b_6_reg + 32'd32768);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t3_reg    <= t_c[15:0];
            e3_reg    <= s1o.err;
            up3_reg   <= s1o.up;
            b6_3_reg  <= b5_c - 32'd4000;

            sq4_reg   <= b6_3_reg * b6_3_reg;
            m2_4_reg  <= ac2 * b6_3_reg;
            m3_4_reg  <= ac3 * b6_3_reg;
            t4_reg    <= t3_reg;
            e4_reg    <= e3_reg;
            up4_reg   <= up3_reg;

            mb2_5_reg <= sqs_c * b2;
            mb1_5_reg <= b1 * sqs_c;
            m2_5_reg  <= m2_4_reg;
            m3_5_reg  <= m3_4_reg;
            t5_reg    <= t4_reg;
            e5_reg    <= e4_reg;
            up5_reg   <= up4_reg;

            b3_6_reg  <= b3_c;
            x3b_6_reg <= x3b_c;
            t6_reg    <= t5_reg;
            e6_reg    <= e5_reg;
            up6_reg   <= up5_reg;

            b4_7_reg  <= b4p_c >> 15;
            b7_7_reg  <= ({8'd0, up6_reg} - b3_6_reg) * (32'd50000 >> oss_reg);
            t7_reg    <= t6_reg;
            e7_reg    <= e6_reg;
        end
    end

    // ---------------- P8: pressure divider setup ----------------
    side2_t      s2_next;
    side2_t      s2_reg [DIV_LAT];
    logic [31:0] n8_c;

    assign n8_c = b7_7_reg[31] ? b7_7_reg : (b7_7_reg << 1);

    always_comb
    begin
        s2_next.t   = t7_reg;
        s2_next.big = b7_7_reg[31];
        if (e7_reg == ERR_OK && b4_7_reg == 32'd0)
            s2_next.err = ERR_PRES;
        else
            s2_next.err = e7_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_reg[0] <= s2_next;
            for (int i = 1; i < DIV_LAT; i++)
                s2_reg[i] <= s2_reg[i-1];
        end
    end

    logic [31:0] quo2;
    bpc_udiv u_div_pres (
        .clk      (clk),
        .en       (adv),
        .dividend (n8_c),
        .divisor  (b4_7_reg),
        .quotient (quo2)
    );

    // ---------------- P9..P12: quadratic correction ----------------
    side2_t      s2o;
    assign s2o = s2_reg[DIV_LAT-1];

    logic [15:0] t9_reg, t10_reg, t11_reg, t12_reg, t13_reg, t14_reg, t15_reg, t16_reg;
    err_t        e9_reg, e10_reg, e11_reg, e12_reg, e13_reg, e14_reg, e15_reg, e16_reg;
    logic [31:0] p9_reg, p10_reg, p11_reg, p12_reg;
    logic [31:0] sqp10_reg, pmh10_reg, pmh11_reg, x1m11_reg;

    logic [31:0] x1s_c, corr_c;
    assign x1s_c  = asr32(p9_reg, 5'd8);
    assign corr_c = asr32(x1m11_reg, 5'd16) + asr32(pmh11_reg, 5'd16) + mi;

    // ---------------- P13..P17: altitude polynomial ----------------
    logic        neg13_reg;
    logic [63:0] rp13_reg;
    logic [31:0] d14_reg, d15_reg, a15_reg, m16_reg;

    logic [31:0] mag_c, q10_c, sq10_c, a256_c, alt_c, c17_c;
    assign mag_c  = p12_reg[31] ? (32'd0 - p12_reg) : p12_reg;
    assign q10_c  = {3'd0, rp13_reg[63:35]};
    assign sq10_c = neg13_reg ? (32'd0 - q10_c) : q10_c;
    // truncating division by 256 and 65536: bias negative values first
    assign a256_c = a15_reg[31] ? asr32(a15_reg + 32'd255, 5'd8) : asr32(a15_reg, 5'd8);
    assign alt_c  = a256_c + 32'd46597;
    assign c17_c  = m16_reg[31] ? asr32(m16_reg + 32'd65535, 5'd16)
                                : asr32(m16_reg, 5'd16);

    logic [15:0] t_out_reg;
    logic [31:0] p_out_reg, alt_out_reg;
    err_t        e_out_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p9_reg    <= s2o.big ? (quo2 << 1) : quo2;
            t9_reg    <= s2o.t;
            e9_reg    <= s2o.err;

            sqp10_reg <= x1s_c * x1s_c;
            pmh10_reg <= p9_reg * mh;
            p10_reg   <= p9_reg;
            t10_reg   <= t9_reg;
            e10_reg   <= e9_reg;

            x1m11_reg <= sqp10_reg * mg;
            pmh11_reg <= pmh10_reg;
            p11_reg   <= p10_reg;
            t11_reg   <= t10_reg;
            e11_reg   <= e10_reg;

            p12_reg   <= p11_reg + asr32(corr_c, 5'd4);
            t12_reg   <= t11_reg;
            e12_reg   <= e11_reg;

            // divide by ten through the reciprocal, exact for 32-bit magnitudes
            rp13_reg  <= {32'd0, mag_c} * 64'hCCCC_CCCD;
            neg13_reg <= p12_reg[31];
            p_out_reg <= p12_reg;
            t13_reg   <= t12_reg;
            e13_reg   <= e12_reg;

            d14_reg   <= 32'd11390 - sq10_c;
            t14_reg   <= t13_reg;
            e14_reg   <= e13_reg;

            a15_reg   <= 32'd745 * d14_reg;
            d15_reg   <= d14_reg;
            t15_reg   <= t14_reg;
            e15_reg   <= e14_reg;

            m16_reg   <= alt_c * d15_reg;
            t16_reg   <= t15_reg;
            e16_reg   <= e15_reg;

            alt_out_reg <= c17_c - 32'd966;
            t_out_reg   <= t16_reg;
            e_out_reg   <= e16_reg;
        end
    end

    // p_out_reg is taken at P13; hold its copy in step with the tail stages
    logic [31:0] p14_reg, p15_reg, p16_reg, p17_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p14_reg <= p_out_reg;
            p15_reg <= p14_reg;
            p16_reg <= p15_reg;
            p17_reg <= p16_reg;
        end
    end

    assign result.valid              = valid_reg[PIPE_DEPTH-1];
    assign result.error_code         = e_out_reg;
    assign result.temperature_tenths = (e_out_reg == ERR_OK) ? t_out_reg : 16'd0;
    assign result.pressure_pa        = (e_out_reg == ERR_OK) ? p17_reg : 32'd0;
    assign result.altitude_m         = (e_out_reg == ERR_OK) ? alt_out_reg : 32'd0;

    // ---------------- assertions ----------------
    a_err_code_legal: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.error_code != 2'd3))
        else $error("error code out of range");

    a_err_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.error_code != ERR_OK) |->
        (result.pressure_pa == 32'd0 && result.altitude_m == 32'd0
         && result.temperature_tenths == 16'd0))
        else $error("error result carries nonzero values");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (sample.valid && sample.ready) |=> valid_reg[0])
        else $error("accepted sample lost at pipeline entry");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!adv) |=> $stable(valid_reg))
        else $error("pipeline moved during stall");

endmodule

`default_nettype wire

FILE: src/bpc_udiv.sv
// Pipelined 32-bit unsigned restoring divider, one quotient bit per stage.
// Depends on bpc_pkg (DIV_LAT).
`timescale 1ns / 1ps
`default_nettype none

module bpc_udiv (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [31:0] dividend,
    input  wire logic [31:0] divisor,
    output logic      [31:0] quotient
);
    import bpc_pkg::*;

    logic [31:0] rem_reg [DIV_LAT];
    logic [31:0] num_reg [DIV_LAT];
    logic [31:0] den_reg [DIV_LAT];

    for (genvar g = 0; g < DIV_LAT; g++) begin : g_stage
        logic [31:0] rem_in;
        logic [31:0] num_in;
        logic [31:0] den_in;
        logic [32:0] trial;
        logic [32:0] diff;
        logic        take;

        if (g == 0) begin : g_first
            assign rem_in = '0;
            assign num_in = dividend;
            assign den_in = divisor;
        end else begin : g_rest
            assign rem_in = rem_reg[g-1];
            assign num_in = num_reg[g-1];
            assign den_in = den_reg[g-1];
        end

        assign trial = {rem_in, num_in[31]};
        assign diff  = trial - {1'b0, den_in};
        assign take  = (trial >= {1'b0, den_in});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g] <= take ? diff[31:0] : trial[31:0];
                num_reg[g] <= {num_in[30:0], take};
                den_reg[g] <= den_in;
            end
        end
    end

    assign quotient = num_reg[DIV_LAT-1];

endmodule

`default_nettype wire
